// ===== src/p2d_ecc_pkg.sv =====
// Shared constants and codes for the two-dimensional parity word ECC block.
`timescale 1ns / 1ps
`default_nettype none

package p2d_ecc_pkg;

  localparam int unsigned DataBytes = 6;
  localparam int unsigned ByteBits  = 8;
  localparam int unsigned DataBits  = DataBytes * ByteBits;  // 48
  localparam int unsigned WordBits  = 64;
  localparam int unsigned CntBits   = 32;
  localparam int unsigned FlipBits  = 6;

  // Bit positions inside the protected word
  localparam int unsigned ColLsb    = DataBits;       // column parity 55:48
  localparam int unsigned RowMetaB  = 56;             // parity over row bits
  localparam int unsigned ColMetaB  = 57;             // parity over column bits
  localparam int unsigned RowTopB   = WordBits - 1;   // row k parity at 63-k

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } opcode_t;

  typedef enum logic [1:0] {
    ST_CLEAN  = 2'd0,
    ST_FIXED  = 2'd1,
    ST_UNCORR = 2'd2
  } status_t;

endpackage : p2d_ecc_pkg

`default_nettype wire

// ===== src/parity_2d_word_ecc_top.sv =====
// Two-dimensional parity encoder / checker-corrector for 48-bit data words.
//
//  channel | ports                                                   | direction
//  --------+---------------------------------------------------------+----------
//  input   | in_valid, in_ready, in_opcode, in_word_in               | in
//  result  | out_valid, out_ready, out_word_out, out_status,         | out
//          | out_bits_flipped, out_fixed_total, out_unfixed_total    |
//
// Words pass an input register, then the parity trees, syndrome and
// correction logic feeding the result register. One word per cycle is
// sustained; the pipeline moves whenever the result register is empty or is
// being taken. A stall on out_ready holds the result register and drops in_ready
// only once the input register is also full. Synchronous active-low reset
// clears the valid flags and the two running counters.
`timescale 1ns / 1ps
`default_nettype none

module parity_2d_word_ecc_top
  import p2d_ecc_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_opcode,
  input  wire logic [WordBits-1:0]  in_word_in,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [WordBits-1:0]       out_word_out,
  output logic [1:0]                out_status,
  output logic [FlipBits-1:0]       out_bits_flipped,
  output logic [CntBits-1:0]        out_fixed_total,
  output logic [CntBits-1:0]        out_unfixed_total
);

  // Pipeline registers
  logic                 s1_valid_r;
  opcode_t              s1_op_r;
  logic [WordBits-1:0]  s1_word_r;
  logic                 out_valid_r;
  logic [WordBits-1:0]  out_word_r;
  status_t              out_status_r;
  logic [FlipBits-1:0]  out_flips_r;
  logic [CntBits-1:0]   fixed_cnt_r;
  logic [CntBits-1:0]   unfixed_cnt_r;

  logic adv_out;
  logic ld_out;

  assign adv_out  = !out_valid_r || out_ready;
  assign ld_out   = s1_valid_r && adv_out;
  assign in_ready = !s1_valid_r || adv_out;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_op_r   <= opcode_t'(in_opcode);
      s1_word_r <= in_word_in;
    end
  end

  // Column and row parities of the data bytes
  logic [DataBits-1:0]  data;
  logic [ByteBits-1:0]  col;
  logic [DataBytes-1:0] rowpar;

  always_comb begin
    data = s1_word_r[DataBits-1:0];
    col  = '0;
    for (int k = 0; k < DataBytes; k++) begin
      col       = col ^ data[k*ByteBits +: ByteBits];
      rowpar[k] = ^data[k*ByteBits +: ByteBits];
    end
  end

  // Encode: data, column parities, row parities and the two meta parities
  logic [WordBits-1:0] enc_word;

  always_comb begin
    enc_word                       = '0;
    enc_word[DataBits-1:0]         = data;
    enc_word[ColLsb +: ByteBits]   = col;
    enc_word[ColMetaB]             = ^col;
    enc_word[RowMetaB]             = ^rowpar;
    for (int k = 0; k < DataBytes; k++) begin
      enc_word[RowTopB - k] = rowpar[k];
    end
  end

  // Decode: syndromes, classification and correction mask
  logic [ByteBits-1:0]  colsyn;
  logic [DataBytes-1:0] rowfail;
  logic [1:0]           meta;
  logic                 row_nz;
  logic                 col_nz;
  logic [2:0]           row_cnt;
  logic [3:0]           col_cnt;
  logic [DataBits-1:0]  fix_mask;

  always_comb begin
    colsyn  = col ^ s1_word_r[ColLsb +: ByteBits];
    for (int k = 0; k < DataBytes; k++) begin
      rowfail[k] = rowpar[k] ^ s1_word_r[RowTopB - k];
    end
    meta[0] = (^s1_word_r[RowTopB -: DataBytes]) ^ s1_word_r[RowMetaB];
    meta[1] = s1_word_r[ColMetaB] ^ (^s1_word_r[ColLsb +: ByteBits]);
    row_nz  = (rowfail != '0) || (meta != '0);
    col_nz  = colsyn != '0;
    row_cnt = '0;
    for (int k = 0; k < DataBytes; k++) begin
      row_cnt = row_cnt + 3'(rowfail[k]);
    end
    col_cnt = '0;
    for (int m = 0; m < ByteBits; m++) begin
      col_cnt = col_cnt + 4'(colsyn[m]);
    end
    for (int k = 0; k < DataBytes; k++) begin
      fix_mask[k*ByteBits +: ByteBits] = rowfail[k] ? colsyn : '0;
    end
  end

  // Result selection
  logic [WordBits-1:0]  res_word;
  status_t              res_status;
  logic [FlipBits-1:0]  res_flips;
  logic                 res_uncorr;

  always_comb begin
    res_word   = enc_word;
    res_status = ST_CLEAN;
    res_flips  = '0;
    res_uncorr = 1'b0;
    if (s1_op_r == OP_DECODE) begin
      res_word = {{(WordBits-DataBits){1'b0}}, data};
      if (row_nz != col_nz) begin
        res_status = ST_UNCORR;
        res_uncorr = 1'b1;
      end else if (row_nz) begin
        res_status = ST_FIXED;
        res_flips  = FlipBits'({3'b000, row_cnt} * {2'b00, col_cnt});
        res_word   = {{(WordBits-DataBits){1'b0}}, data ^ fix_mask};
      end
    end
  end

  // Result register and running counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r   <= 1'b0;
      fixed_cnt_r   <= '0;
      unfixed_cnt_r <= '0;
    end else begin
      if (adv_out) begin
        out_valid_r <= s1_valid_r;
      end
      if (ld_out) begin
        fixed_cnt_r   <= fixed_cnt_r + CntBits'(res_flips);
        unfixed_cnt_r <= unfixed_cnt_r + CntBits'(res_uncorr);
      end
    end
    if (ld_out) begin
      out_word_r   <= res_word;
      out_status_r <= res_status;
      out_flips_r  <= res_flips;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_word_out      = out_word_r;
  assign out_status        = out_status_r;
  assign out_bits_flipped  = out_flips_r;
  assign out_fixed_total   = fixed_cnt_r;
  assign out_unfixed_total = unfixed_cnt_r;

  // Checks
  a_clean_no_flips: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_FIXED) |-> out_flips_r == '0)
    else $error("flips reported without a correction");

  a_flips_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_flips_r <= FlipBits'(DataBits))
    else $error("flip count beyond data width");

  a_unfixed_step: assert property (@(posedge clk) disable iff (!rst_n)
    ld_out |=> unfixed_cnt_r == $past(unfixed_cnt_r) + CntBits'($past(res_uncorr)))
    else $error("uncorrectable counter out of step");

  a_counters_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !ld_out |=> $stable(fixed_cnt_r) && $stable(unfixed_cnt_r))
    else $error("counter moved without a word");

  a_decode_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_status_r != ST_CLEAN) |-> out_word_r[WordBits-1:DataBits] == '0)
    else $error("decode left check bits set");

endmodule : parity_2d_word_ecc_top

`default_nettype wire

// ===== verif/p2d_ecc_checker.sv =====
// Checker for the 2D parity ECC block: watches both channels, predicts and compares.
`timescale 1ns / 1ps

module p2d_ecc_checker
  import p2d_ecc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_opcode,
  input  logic [63:0] in_word_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [63:0] out_word_out,
  input  logic [1:0]  out_status,
  input  logic [5:0]  out_bits_flipped,
  input  logic [31:0] out_fixed_total,
  input  logic [31:0] out_unfixed_total,
  output int          mismatches,
  output int          outstanding
);

  typedef struct packed {
    logic [63:0] word;
    status_t     status;
    logic [5:0]  flips;
    logic [31:0] fixed_cnt;
    logic [31:0] unfixed_cnt;
  } ecc_result_t;

  ecc_result_t expected_words[$];
  logic [31:0] fixed_bits_q   = '0;
  logic [31:0] unfixed_words_q = '0;
  int          fail_cnt    = 0;
  int          pending_cnt = 0;

  assign mismatches  = fail_cnt;
  assign outstanding = pending_cnt;

  // Protected word for 48 data bits: column parity, row parity, two meta bits
  function automatic logic [63:0] protect_data(input logic [47:0] d);
    logic [63:0] w;
    logic [7:0]  col;
    logic [5:0]  rows;
    int          k;
    col = '0;
    for (k = 0; k < DataBytes; k++) begin
      col ^= d[8*k +: 8];
      rows[k] = ^d[8*k +: 8];
    end
    w = {16'h0, d};
    w[55:48] = col;
    for (k = 0; k < DataBytes; k++) w[RowTopB - k] = rows[k];
    w[ColMetaB] = ^col;
    w[RowMetaB] = ^rows;
    return w;
  endfunction

  // Expected result of one word; advances the running counters
  function automatic ecc_result_t predict_word(input logic op, input logic [63:0] w);
    ecc_result_t r;
    logic [47:0] data;
    logic [63:0] pw;
    logic [7:0]  col_syn;
    logic [5:0]  row_fail;
    logic [1:0]  meta;
    logic [5:0]  nflip;
    int          k;
    int          m;
    data    = w[47:0];
    r.word  = {16'h0, data};
    r.status = ST_CLEAN;
    nflip   = '0;
    if (op == OP_ENCODE) begin
      r.word = protect_data(data);
    end else begin
      pw      = protect_data(data);
      col_syn = pw[55:48];
      col_syn ^= w[55:48];
      for (k = 0; k < DataBytes; k++) row_fail[k] = (^data[8*k +: 8]) ^ w[RowTopB - k];
      meta[0] = (^w[63:58]) ^ w[RowMetaB];
      meta[1] = (^w[55:48]) ^ w[ColMetaB];
      if ((|{row_fail, meta}) != (|col_syn)) begin
        r.status = ST_UNCORR;
        unfixed_words_q += 32'd1;
      end else if (|{row_fail, meta}) begin
        // flip every data bit at a failing row and failing column
        r.status = ST_FIXED;
        for (k = 0; k < DataBytes; k++)
          for (m = 0; m < ByteBits; m++)
            if (row_fail[k] && col_syn[m]) begin
              r.word[8*k + m] = ~r.word[8*k + m];
              nflip += 6'd1;
            end
        fixed_bits_q += 32'(nflip);
      end
    end
    r.flips       = nflip;
    r.fixed_cnt   = fixed_bits_q;
    r.unfixed_cnt = unfixed_words_q;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    fail_cnt++;
    if (fail_cnt <= 40) $display("chk: %s: got %h, want %h", what, got, want);
  endtask

  // Sample both channels at the rising edge
  always @(posedge clk) begin
    ecc_result_t want;
    if (!rst_n) begin
      expected_words.delete();
      fixed_bits_q    = '0;
      unfixed_words_q = '0;
    end else begin
      if (in_valid && in_ready) expected_words.push_back(predict_word(in_opcode, in_word_in));
      if (out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("word with none expected", out_word_out, '0);
        end else begin
          want = expected_words.pop_front();
          if (out_word_out !== want.word)
            report_mismatch("word_out", out_word_out, want.word);
          if (out_status !== want.status)
            report_mismatch("status", 64'(out_status), 64'(want.status));
          if (out_bits_flipped !== want.flips)
            report_mismatch("bits_flipped", 64'(out_bits_flipped), 64'(want.flips));
          if (out_fixed_total !== want.fixed_cnt)
            report_mismatch("fixed_total", 64'(out_fixed_total), 64'(want.fixed_cnt));
          if (out_unfixed_total !== want.unfixed_cnt)
            report_mismatch("unfixed_total", 64'(out_unfixed_total), 64'(want.unfixed_cnt));
        end
      end
    end
    pending_cnt = expected_words.size();
  end

endmodule

// ===== verif/tb.sv =====
// Testbench top for the 2D parity ECC block: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
  import p2d_ecc_pkg::*;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_opcode  = 1'b0;
  logic [63:0] in_word_in = '0;
  logic        out_ready  = 1'b0;
  logic        in_ready;
  logic        out_valid;
  logic [63:0] out_word_out;
  logic [1:0]  out_status;
  logic [5:0]  out_bits_flipped;
  logic [31:0] out_fixed_total;
  logic [31:0] out_unfixed_total;
  int          mismatches;
  int          outstanding;
  bit          bursty = 1'b1;  // random idling on both sides when set

  parity_2d_word_ecc_top uut (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_word_in,
    .out_valid, .out_ready, .out_word_out, .out_status, .out_bits_flipped,
    .out_fixed_total, .out_unfixed_total
  );

  p2d_ecc_checker chk (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_word_in,
    .out_valid, .out_ready, .out_word_out, .out_status, .out_bits_flipped,
    .out_fixed_total, .out_unfixed_total, .mismatches, .outstanding
  );

  always #4 clk = ~clk;

  // Receiver stalls
  always @(negedge clk) begin
    out_ready <= bursty ? ($urandom_range(99) >= 17) : 1'b1;
  end

  // Present one word and hold it until taken; returns on a falling edge
  task automatic send_word(input opcode_t op, input logic [63:0] w);
    while (bursty && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_word_in <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Hold off the sender until every expected word is back
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (outstanding != 0) @(negedge clk);
  endtask

  initial begin
    logic [63:0] code;
    logic [63:0] rnd;
    logic [63:0] hits [12];
    int          i;
    int          pick;

    repeat (9) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Encode extremes; upper bits of the input must be ignored
    send_word(OP_ENCODE, 64'h0);
    send_word(OP_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(OP_ENCODE, 64'h0000_FFFF_FFFF_FFFF);
    send_word(OP_ENCODE, 64'hABCD_A5A5_5A5A_0F0F);

    // Decode: clean, single data errors, check-bit errors, multi-bit patterns
    hits = '{64'h0, 64'h1, 64'h0000_8000_0000_0000, 64'h0001_0000_0000_0000,
             64'h0080_0000_0000_0000, 64'h0100_0000_0000_0000,
             64'h0200_0000_0000_0000, 64'h0400_0000_0000_0000,
             64'h8000_0000_0000_0000, 64'h0000_0000_0000_0028,
             64'h0000_0040_0000_0004, 64'h0000_FFFF_FFFF_FFFF};
    foreach (hits[j]) send_word(OP_DECODE, chk.protect_data(48'h1234_5678_9ABC) ^ hits[j]);
    send_word(OP_DECODE, 64'h0);
    send_word(OP_DECODE, chk.protect_data(48'hFFFF_FFFF_FFFF));
    // every row and every column failing: all 48 data bits flip
    send_word(OP_DECODE, 64'hFCFF_0000_0000_0000);
    send_word(OP_DECODE, 64'hFFFF_FFFF_FFFF_FFFF);
    drain();

    // Random words: encodes, and decodes of codewords with up to four flipped bits or of random words
    for (i = 0; i < 1600; i++) begin
      bursty = !(i >= 600 && i < 1000);
      if (i == 800) drain();
      rnd  = {$urandom, $urandom};
      pick = $urandom_range(99);
      if (pick < 30) begin
        send_word(OP_ENCODE, rnd);
      end else begin
        code = chk.protect_data(rnd[47:0]);
        pick = $urandom_range(99);
        if (pick >= 90) begin
          code = {$urandom, $urandom};
        end else if (pick >= 80) begin
          repeat ($urandom_range(4, 3)) code[$urandom_range(63)] ^= 1'b1;
        end else if (pick >= 65) begin
          code[$urandom_range(63)] ^= 1'b1;
          code[$urandom_range(63)] ^= 1'b1;
        end else if (pick >= 35) begin
          code[$urandom_range(63)] ^= 1'b1;
        end
        send_word(OP_DECODE, code);
      end
    end
    in_valid <= 1'b0;

    // Let the pipeline empty, then keep watching for stray words
    while (outstanding != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// ===== parity_2d_word_ecc_top.f =====
src/p2d_ecc_pkg.sv
src/parity_2d_word_ecc_top.sv
verif/p2d_ecc_checker.sv
verif/tb.sv
